// ----- sv/frr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frr_pkg
// shared word types and fixed widths of the fresnel reflectance pipeline
// ----------------------------------------------------------------------------
package frr_pkg;

	localparam int IN_W    = 16;   // input component width
	localparam int IOR_W   = 14;   // refractive index, unsigned Q2.12
	localparam int Q30_W   = 31;   // unsigned Q.30 values up to 1.0
	localparam int RAD_W   = 62;   // radicand of the square root chains
	localparam int PROD_W  = 45;   // Q.30 times Q2.12
	localparam int DEN_W   = 46;   // sum of two products
	localparam int NUM_W   = 64;   // ratio dividend, numerator shifted to Q.18
	localparam int RAT_W   = 19;   // Q.18 ratio up to 1.0
	localparam int OUT_W   = 16;

	localparam logic [IOR_W-1:0] IOR_RESET = 14'd5734;
	localparam logic [IOR_W-1:0] IOR_ONE   = 14'd4096;
	localparam logic [IOR_W-1:0] IOR_MIN   = 14'd1;
	localparam logic [Q30_W-1:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [RAT_W-1:0] RAT_ONE   = 19'h4_0000;
	localparam logic [OUT_W-1:0] OUT_ONE   = 16'h8000;

	typedef struct packed {
		logic signed [IN_W-1:0] incident_x;
		logic signed [IN_W-1:0] incident_y;
		logic signed [IN_W-1:0] incident_z;
		logic signed [IN_W-1:0] normal_x;
		logic signed [IN_W-1:0] normal_y;
		logic signed [IN_W-1:0] normal_z;
	} in_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] reflectance;
		logic             total_internal;
	} out_word_t;

endpackage
`default_nettype wire

// ----- sv/frr_sqrt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frr_sqrt_cell
// one root bit of a digit-by-digit integer square root, registered
// ----------------------------------------------------------------------------
module frr_sqrt_cell #(
	parameter int W_R = 31,
	parameter int K   = 0,
	parameter int W_S = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 src_valid,
	input  wire logic [2*W_R-1:0]     src_rad,
	input  wire logic [W_R+1:0]       src_rem,
	input  wire logic [W_R-1:0]       src_root,
	input  wire logic [W_S-1:0]       src_side,
	output logic                      valid,
	output logic [2*W_R-1:0]          rad,
	output logic [W_R+1:0]            rem,
	output logic [W_R-1:0]            root,
	output logic [W_S-1:0]            side
);

	logic [W_R+3:0] shifted;
	logic [W_R+3:0] trial;
	logic           ge;
	logic [W_R+3:0] diff;

	always_comb begin
		shifted = {src_rem, src_rad[2*K+1 -: 2]};
		trial   = {2'b00, src_root, 2'b01};
		ge      = shifted >= trial;
		diff    = ge ? (shifted - trial) : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad  <= src_rad;
			rem  <= diff[W_R+1:0];
			root <= {src_root[W_R-2:0], ge};
			side <= src_side;
		end
	end

endmodule
`default_nettype wire

// ----- sv/frr_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frr_div_cell
// one quotient bit of a restoring divider, registered
// ----------------------------------------------------------------------------
module frr_div_cell #(
	parameter int W_R = 45,
	parameter int W_D = 14,
	parameter int W_Q = 30,
	parameter int K   = 0,
	parameter int W_S = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              src_valid,
	input  wire logic [W_R-1:0]    src_rem,
	input  wire logic [W_D-1:0]    src_dvs,
	input  wire logic [W_Q-1:0]    src_quot,
	input  wire logic [W_S-1:0]    src_side,
	output logic                   valid,
	output logic [W_R-1:0]         rem,
	output logic [W_D-1:0]         dvs,
	output logic [W_Q-1:0]         quot,
	output logic [W_S-1:0]         side
);

	logic [W_R-1:0] shifted;
	logic           ge;
	logic [W_Q-1:0] quot_n;

	always_comb begin
		shifted   = {{(W_R-W_D){1'b0}}, src_dvs} << K;
		ge        = src_rem >= shifted;
		quot_n    = src_quot;
		quot_n[K] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem  <= ge ? (src_rem - shifted) : src_rem;
			dvs  <= src_dvs;
			quot <= quot_n;
			side <= src_side;
		end
	end

endmodule
`default_nettype wire

// ----- sv/fresnel_reflectance_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_reflectance_top
// unpolarized dielectric fresnel reflectance; unstalled, it takes one word per cycle
// ----------------------------------------------------------------------------
// datapath: the cell chains are two 31-cell square roots, a 30-cell divider
//   and two parallel 19-cell ratio dividers
// throughput: one word per cycle; the whole pipe advances unless the output
//   register holds a word that is stalled
// reset: arst_n clears all valid bits and loads refractive_index with 5734
module fresnel_reflectance_top #(
	parameter int FRACTION_BITS = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire frr_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output frr_pkg::out_word_t      out_word,
	input  wire logic               cfg_we,
	input  wire logic [13:0]        cfg_data
);

	localparam int QW   = frr_pkg::Q30_W;
	localparam int IW   = frr_pkg::IOR_W;
	localparam int RW   = frr_pkg::RAD_W;
	localparam int PW   = frr_pkg::PROD_W;
	localparam int DW   = frr_pkg::DEN_W;
	localparam int NW   = frr_pkg::NUM_W;
	localparam int AW   = frr_pkg::RAT_W;
	// dot product has 2*FRACTION_BITS fraction bits, moved to Q.30
	localparam int PROD_BITS = 2 * FRACTION_BITS;
	localparam int SHR  = (PROD_BITS >= 30) ? (PROD_BITS - 30) : 0;
	localparam int SHL  = (PROD_BITS < 30) ? (30 - PROD_BITS) : 0;
	localparam int SQ_N = QW;        // cells per square root
	localparam int DV_N = QW - 1;    // cells of the sine divider
	localparam int RT_N = AW;        // cells per ratio divider
	localparam int SA_W = 1 + QW;               // inside, ci
	localparam int SD_W = 1 + QW + IW;          // tir, ci, ni
	localparam int SB_W = 1 + QW + 2 * IW;      // tir, ci, ni, nt

	// global advance: everything moves unless the output word is held
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// refractive index register
	logic [IW-1:0] ior_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ior_q <= frr_pkg::IOR_RESET;
		end else if (cfg_we) begin
			ior_q <= cfg_data;
		end
	end

	logic [IW-1:0] n_ior;
	assign n_ior = (ior_q == '0) ? frr_pkg::IOR_MIN : ior_q;

	// ------------------------------------------------------------------
	// s1: component products
	logic               v_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= in_word.incident_x * in_word.normal_x;
			py_s1 <= in_word.incident_y * in_word.normal_y;
			pz_s1 <= in_word.incident_z * in_word.normal_z;
		end
	end

	// ------------------------------------------------------------------
	// s2: dot sum, side of the surface, |c| clamped to 1.0 in Q.30
	logic signed [33:0] dot;
	logic [32:0]        dmag;
	logic [43:0]        dq30;
	logic [QW-1:0]      ci_n;

	always_comb begin
		dot  = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		dmag = dot[33] ? 33'(-dot) : dot[32:0];
		dq30 = (44'(dmag) >> SHR) << SHL;
		ci_n = (dq30 > 44'(frr_pkg::Q30_ONE)) ? frr_pkg::Q30_ONE : dq30[QW-1:0];
	end

	logic          v_s2;
	logic          inside_s2;
	logic [QW-1:0] ci_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s2 <= (dot > 34'sd0);
			ci_s2     <= ci_n;
		end
	end

	// ------------------------------------------------------------------
	// s3: 1 - c^2, the radicand of the incident sine
	logic [2*QW-1:0] cc;
	assign cc = ci_s2 * ci_s2;

	logic          v_s3;
	logic          inside_s3;
	logic [QW-1:0] ci_s3;
	logic [QW-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s3 <= inside_s2;
			ci_s3     <= ci_s2;
			rad_s3    <= frr_pkg::Q30_ONE - cc[2*QW-2:30];
		end
	end

	// ------------------------------------------------------------------
	// square root chain a: sin(theta_i)
	logic [SQ_N:0]            va;
	logic [SQ_N:0][RW-1:0]    rada;
	logic [SQ_N:0][QW+1:0]    rema;
	logic [SQ_N:0][QW-1:0]    roota;
	logic [SQ_N:0][SA_W-1:0]  sidea;

	assign va[0]    = v_s3;
	assign rada[0]  = {1'b0, rad_s3, 30'b0};
	assign rema[0]  = '0;
	assign roota[0] = '0;
	assign sidea[0] = {inside_s3, ci_s3};

	for (genvar g = 0; g < SQ_N; g++) begin : g_sqa
		frr_sqrt_cell #(.W_R(QW), .K(SQ_N-1-g), .W_S(SA_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.src_valid(va[g]), .src_rad(rada[g]), .src_rem(rema[g]),
			.src_root(roota[g]), .src_side(sidea[g]),
			.valid(va[g+1]), .rad(rada[g+1]), .rem(rema[g+1]),
			.root(roota[g+1]), .side(sidea[g+1])
		);
	end

	// ------------------------------------------------------------------
	// s4: pick indices by side, sini * ni
	logic          inside_a;
	logic [QW-1:0] ci_a;
	logic [IW-1:0] ni_n, nt_n;
	assign {inside_a, ci_a} = sidea[SQ_N];
	assign ni_n = inside_a ? n_ior : frr_pkg::IOR_ONE;
	assign nt_n = inside_a ? frr_pkg::IOR_ONE : n_ior;

	logic          v_s4;
	logic [PW-1:0] prod_s4;
	logic [IW-1:0] ni_s4, nt_s4;
	logic [QW-1:0] ci_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= va[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= roota[SQ_N] * ni_n;
			ni_s4   <= ni_n;
			nt_s4   <= nt_n;
			ci_s4   <= ci_a;
		end
	end

	// ------------------------------------------------------------------
	// s5: total internal reflection when sini*ni reaches nt
	logic          v_s5;
	logic          tir_s5;
	logic [PW-1:0] prod_s5;
	logic [IW-1:0] ni_s5, nt_s5;
	logic [QW-1:0] ci_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s5  <= prod_s4 >= {1'b0, nt_s4, 30'b0};
			prod_s5 <= prod_s4;
			ni_s5   <= ni_s4;
			nt_s5   <= nt_s4;
			ci_s5   <= ci_s4;
		end
	end

	// ------------------------------------------------------------------
	// divider chain: sint = sini*ni / nt, 30 quotient bits suffice below tir
	logic [DV_N:0]            vd;
	logic [DV_N:0][PW-1:0]    remd;
	logic [DV_N:0][IW-1:0]    dvsd;
	logic [DV_N:0][QW-2:0]    quotd;
	logic [DV_N:0][SD_W-1:0]  sided;

	assign vd[0]    = v_s5;
	assign remd[0]  = prod_s5;
	assign dvsd[0]  = nt_s5;
	assign quotd[0] = '0;
	assign sided[0] = {tir_s5, ci_s5, ni_s5};

	for (genvar g = 0; g < DV_N; g++) begin : g_div
		frr_div_cell #(.W_R(PW), .W_D(IW), .W_Q(QW-1), .K(DV_N-1-g), .W_S(SD_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.src_valid(vd[g]), .src_rem(remd[g]), .src_dvs(dvsd[g]),
			.src_quot(quotd[g]), .src_side(sided[g]),
			.valid(vd[g+1]), .rem(remd[g+1]), .dvs(dvsd[g+1]),
			.quot(quotd[g+1]), .side(sided[g+1])
		);
	end

	// ------------------------------------------------------------------
	// s6: 1 - sint^2, radicand of the transmitted cosine
	logic [2*QW-3:0] ss;
	assign ss = quotd[DV_N] * quotd[DV_N];

	logic          v_s6;
	logic [QW-1:0] rad_s6;
	logic [SB_W-1:0] side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= vd[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s6  <= frr_pkg::Q30_ONE - {1'b0, ss[2*QW-3:30]};
			side_s6 <= {sided[DV_N], dvsd[DV_N]};
		end
	end

	// ------------------------------------------------------------------
	// square root chain b: cos(theta_t)
	logic [SQ_N:0]            vb;
	logic [SQ_N:0][RW-1:0]    radb;
	logic [SQ_N:0][QW+1:0]    remb;
	logic [SQ_N:0][QW-1:0]    rootb;
	logic [SQ_N:0][SB_W-1:0]  sideb;

	assign vb[0]    = v_s6;
	assign radb[0]  = {1'b0, rad_s6, 30'b0};
	assign remb[0]  = '0;
	assign rootb[0] = '0;
	assign sideb[0] = side_s6;

	for (genvar g = 0; g < SQ_N; g++) begin : g_sqb
		frr_sqrt_cell #(.W_R(QW), .K(SQ_N-1-g), .W_S(SB_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.src_valid(vb[g]), .src_rad(radb[g]), .src_rem(remb[g]),
			.src_root(rootb[g]), .src_side(sideb[g]),
			.valid(vb[g+1]), .rad(radb[g+1]), .rem(remb[g+1]),
			.root(rootb[g+1]), .side(sideb[g+1])
		);
	end

	// ------------------------------------------------------------------
	// s7: the four index-weighted cosines
	logic          tir_b;
	logic [QW-1:0] ci_b;
	logic [IW-1:0] ni_b, nt_b;
	assign {tir_b, ci_b, ni_b, nt_b} = sideb[SQ_N];

	logic          v_s7;
	logic          tir_s7;
	logic [PW-1:0] as_s7, bs_s7, ap_s7, bp_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= vb[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s7 <= tir_b;
			as_s7  <= nt_b * ci_b;
			bs_s7  <= ni_b * rootb[SQ_N];
			ap_s7  <= ni_b * ci_b;
			bp_s7  <= nt_b * rootb[SQ_N];
		end
	end

	// ------------------------------------------------------------------
	// s8: numerator and denominator of both ratios
	logic          v_s8;
	logic          tir_s8;
	logic          zs_s8, zp_s8;
	logic [NW-1:0] nums_s8, nump_s8;
	logic [DW-1:0] dens_s8, denp_s8;
	logic [PW-1:0] dfs, dfp;

	always_comb begin
		dfs = (as_s7 > bs_s7) ? (as_s7 - bs_s7) : (bs_s7 - as_s7);
		dfp = (ap_s7 > bp_s7) ? (ap_s7 - bp_s7) : (bp_s7 - ap_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s8  <= tir_s7;
			dens_s8 <= DW'(as_s7) + DW'(bs_s7);
			denp_s8 <= DW'(ap_s7) + DW'(bp_s7);
			zs_s8   <= (as_s7 == '0) && (bs_s7 == '0);
			zp_s8   <= (ap_s7 == '0) && (bp_s7 == '0);
			nums_s8 <= {1'b0, dfs, 18'b0};
			nump_s8 <= {1'b0, dfp, 18'b0};
		end
	end

	// ------------------------------------------------------------------
	// ratio divider chains, s and p side by side
	logic [RT_N:0]            vrs, vrp;
	logic [RT_N:0][NW-1:0]    rems, remp;
	logic [RT_N:0][DW-1:0]    dvss, dvsp;
	logic [RT_N:0][AW-1:0]    quots, quotp;
	logic [RT_N:0][1:0]       sides;
	logic [RT_N:0][0:0]       sidep;

	assign vrs[0]   = v_s8;
	assign rems[0]  = nums_s8;
	assign dvss[0]  = dens_s8;
	assign quots[0] = '0;
	assign sides[0] = {tir_s8, zs_s8};
	assign vrp[0]   = v_s8;
	assign remp[0]  = nump_s8;
	assign dvsp[0]  = denp_s8;
	assign quotp[0] = '0;
	assign sidep[0] = zp_s8;

	for (genvar g = 0; g < RT_N; g++) begin : g_rat
		frr_div_cell #(.W_R(NW), .W_D(DW), .W_Q(AW), .K(RT_N-1-g), .W_S(2)) u_cs (
			.clk(clk), .arst_n(arst_n), .en(en),
			.src_valid(vrs[g]), .src_rem(rems[g]), .src_dvs(dvss[g]),
			.src_quot(quots[g]), .src_side(sides[g]),
			.valid(vrs[g+1]), .rem(rems[g+1]), .dvs(dvss[g+1]),
			.quot(quots[g+1]), .side(sides[g+1])
		);
		frr_div_cell #(.W_R(NW), .W_D(DW), .W_Q(AW), .K(RT_N-1-g), .W_S(1)) u_cp (
			.clk(clk), .arst_n(arst_n), .en(en),
			.src_valid(vrp[g]), .src_rem(remp[g]), .src_dvs(dvsp[g]),
			.src_quot(quotp[g]), .src_side(sidep[g]),
			.valid(vrp[g+1]), .rem(remp[g+1]), .dvs(dvsp[g+1]),
			.quot(quotp[g+1]), .side(sidep[g+1])
		);
	end

	// ------------------------------------------------------------------
	// s9: squared ratios, a zero denominator counts as ratio one
	logic [AW-1:0]   rs, rp;
	assign rs = sides[RT_N][0] ? frr_pkg::RAT_ONE : quots[RT_N];
	assign rp = sidep[RT_N][0] ? frr_pkg::RAT_ONE : quotp[RT_N];

	logic              v_s9;
	logic              tir_s9;
	logic [2*AW-1:0]   rs2_s9, rp2_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= vrs[RT_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s9 <= sides[RT_N][1];
			rs2_s9 <= rs * rs;
			rp2_s9 <= rp * rp;
		end
	end

	// ------------------------------------------------------------------
	// output register: mean of squares to Q1.15, saturate, tir override
	logic [2*AW:0]  ksum;
	logic [16:0]    kr;
	assign ksum = (2*AW+1)'(rs2_s9) + (2*AW+1)'(rp2_s9);
	assign kr   = ksum[2*AW:22];

	logic                out_valid_q;
	frr_pkg::out_word_t  out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tir_s9) begin
				out_word_q.reflectance <= frr_pkg::OUT_ONE;
			end else if (kr > 17'(frr_pkg::OUT_ONE)) begin
				out_word_q.reflectance <= frr_pkg::OUT_ONE;
			end else begin
				out_word_q.reflectance <= kr[15:0];
			end
			out_word_q.total_internal <= tir_s9;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// ------------------------------------------------------------------
	// checks
	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.total_internal |-> out_word.reflectance == frr_pkg::OUT_ONE)
		else $error("tir word without full reflectance");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.reflectance <= frr_pkg::OUT_ONE)
		else $error("reflectance above one");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		vrs[RT_N] == vrp[RT_N])
		else $error("ratio lanes out of step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s1))
		else $error("pipe moved while stalled");

endmodule
`default_nettype wire
